// ===== hdl/dftc_pkg.sv =====
// package for the decimal frame to tuning code block
// holds field widths, frame layout, segment table and the result type; no dependencies
`default_nettype none

package dftc_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned CODE_W   = 12;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned WEIGHT_W = 10;
  localparam int unsigned NUM_SEG  = 5;
  localparam int unsigned X_W      = 20;
  localparam int unsigned OFFS_W   = 18;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned PROD_W   = X_W + GAIN_W;
  localparam int unsigned CODE_LSB = 32;

  localparam int unsigned MID_DEPTH_DEF = 2;
  localparam int unsigned OUT_DEPTH_DEF = 4;

  // frame positions
  localparam logic [COUNT_W-1:0] POS_THOUSANDS = 3'd2;
  localparam logic [COUNT_W-1:0] POS_HUNDREDS  = 3'd3;
  localparam logic [COUNT_W-1:0] POS_TENS      = 3'd4;
  localparam logic [COUNT_W-1:0] POS_LAST      = 3'd5;

  localparam logic [FREQ_W-1:0] DIGIT_BASE = 16'd48;
  localparam logic [FREQ_W-1:0] FREQ_MIN   = 16'd1000;
  localparam logic [FREQ_W-1:0] FREQ_MAX   = 16'd2000;

  localparam logic [WEIGHT_W-1:0] W_THOUSANDS = 10'd1000;
  localparam logic [WEIGHT_W-1:0] W_HUNDREDS  = 10'd100;
  localparam logic [WEIGHT_W-1:0] W_TENS      = 10'd10;
  localparam logic [WEIGHT_W-1:0] W_ONES      = 10'd1;

  typedef logic [FREQ_W-1:0] seg_upper_arr_t [NUM_SEG];
  typedef logic signed [OFFS_W-1:0] seg_offs_arr_t [NUM_SEG];
  typedef logic [GAIN_W-1:0] seg_gain_arr_t [NUM_SEG];

  // inclusive upper bound, offset in q8, gain in q24
  localparam seg_upper_arr_t SEG_UPPER = '{16'd1200, 16'd1400, 16'd1600, 16'd1800, 16'd2000};
  localparam seg_offs_arr_t  SEG_OFFS  = '{18'sd37394, -18'sd4655, 18'sd37076,
                                           -18'sd14055, 18'sd108116};
  localparam seg_gain_arr_t  SEG_GAIN  = '{24'd13677403, 24'd11833318, 24'd13370393,
                                           24'd11756372, 24'd15829029};

  typedef struct packed {
    logic [FREQ_W-1:0] freq_value;
    logic [CODE_W-1:0] dac_code;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/dftc_queue.sv =====
// small first-in first-out queue with occupancy count
// register-file storage; no package dependency
`default_nettype none

module dftc_queue #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned WIDTH = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       push,
  input  wire logic [WIDTH-1:0]           wdata,
  output logic                            full,
  input  wire logic                       pop,
  output logic [WIDTH-1:0]                rdata,
  output logic                            empty,
  output logic [$clog2(DEPTH+1)-1:0]      count
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == FULL_CNT);
  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dftc_front.sv =====
// front end: frame position counter and decimal digit accumulator
// depends on dftc_pkg; hands each finished frequency to the middle queue
`default_nettype none

module dftc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  input  wire logic [dftc_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                              in_full,
  input  wire logic                         mid_full,
  output logic                              mid_push,
  output logic [dftc_pkg::FREQ_W-1:0]       mid_freq
);

  import dftc_pkg::*;

  logic [COUNT_W-1:0]          byte_count_r, byte_count_nxt;
  logic [FREQ_W-1:0]           digit_accum_r, digit_accum_nxt;
  logic                        accept;
  logic                        is_digit_pos;
  logic                        is_last;
  logic [WEIGHT_W-1:0]         weight;
  logic [FREQ_W-1:0]           digit;
  logic [FREQ_W+WEIGHT_W-1:0]  term_full;
  logic [FREQ_W-1:0]           sum;

  assign in_full      = mid_full;
  assign accept       = in_push && !mid_full;
  assign is_digit_pos = (byte_count_r >= POS_THOUSANDS);
  // counts of six and seven are handled as the last byte
  assign is_last      = (byte_count_r >= POS_LAST);

  always_comb begin
    case (byte_count_r)
      POS_THOUSANDS: weight = W_THOUSANDS;
      POS_HUNDREDS:  weight = W_HUNDREDS;
      POS_TENS:      weight = W_TENS;
      default:       weight = W_ONES;
    endcase
  end

  // no digit check, wraps mod 2^16
  assign digit     = {{(FREQ_W-BYTE_W){1'b0}}, in_rx_byte} - DIGIT_BASE;
  assign term_full = digit * weight;
  assign sum       = digit_accum_r + term_full[FREQ_W-1:0];

  always_comb begin
    byte_count_nxt  = byte_count_r;
    digit_accum_nxt = digit_accum_r;
    if (accept) begin
      if (is_last) begin
        byte_count_nxt  = '0;
        digit_accum_nxt = '0;
      end else begin
        byte_count_nxt = byte_count_r + 1'b1;
        if (is_digit_pos) begin
          digit_accum_nxt = sum;
        end
      end
    end
  end

  assign mid_push = accept && is_last;
  assign mid_freq = sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r  <= '0;
      digit_accum_r <= '0;
    end else begin
      byte_count_r  <= byte_count_nxt;
      digit_accum_r <= digit_accum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dftc_back.sv =====
// back end: two-stage segment lookup and q24 gain multiply
// depends on dftc_pkg; issues against credit in the result queue
`default_nettype none

module dftc_back #(
  parameter int unsigned OUT_DEPTH = dftc_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            mid_empty,
  input  wire logic [dftc_pkg::FREQ_W-1:0]     mid_freq,
  output logic                                 mid_pop,
  input  wire logic [$clog2(OUT_DEPTH+1)-1:0]  out_count,
  output logic                                 res_push,
  output dftc_pkg::result_t                    res_data
);

  import dftc_pkg::*;

  localparam int unsigned CW = $clog2(OUT_DEPTH + 1);
  localparam logic [CW:0] CREDIT_MAX = (CW+1)'(OUT_DEPTH);

  logic [CW:0]               in_use;
  logic                      issue;
  logic                      in_range;
  logic [FREQ_W-1:0]         sel_upper_dummy;
  logic signed [OFFS_W-1:0]  sel_offs;
  logic [GAIN_W-1:0]         sel_gain;
  logic                      found;
  logic signed [X_W:0]       x_s;
  logic [PROD_W-1:0]         prod;

  logic                      v1_r;
  logic [FREQ_W-1:0]         f1_r;
  logic [X_W-1:0]            x1_r;
  logic [GAIN_W-1:0]         g1_r;
  logic                      z1_r;
  logic                      v2_r;
  logic [FREQ_W-1:0]         f2_r;
  logic [CODE_W-1:0]         c2_r;

  // results in flight count against the result queue space
  assign in_use  = {1'b0, out_count} + (CW+1)'(v1_r) + (CW+1)'(v2_r);
  assign issue   = !mid_empty && (in_use < CREDIT_MAX);
  assign mid_pop = issue;

  assign in_range = (mid_freq >= FREQ_MIN) && (mid_freq <= FREQ_MAX);

  // first segment whose upper bound covers the value
  always_comb begin
    sel_offs        = SEG_OFFS[NUM_SEG-1];
    sel_gain        = SEG_GAIN[NUM_SEG-1];
    sel_upper_dummy = SEG_UPPER[NUM_SEG-1];
    found           = 1'b0;
    for (int i = 0; i < NUM_SEG; i++) begin
      if (!found && (mid_freq <= SEG_UPPER[i])) begin
        found           = 1'b1;
        sel_offs        = SEG_OFFS[i];
        sel_gain        = SEG_GAIN[i];
        sel_upper_dummy = SEG_UPPER[i];
      end
    end
  end

  assign x_s = $signed({1'b0, mid_freq[X_W-9:0], 8'b0})
             - $signed({{(X_W+1-OFFS_W){sel_offs[OFFS_W-1]}}, sel_offs});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      f1_r <= mid_freq;
      x1_r <= x_s[X_W-1:0];
      g1_r <= sel_gain;
      z1_r <= !in_range || x_s[X_W] || (sel_upper_dummy < mid_freq);
    end
    if (v1_r) begin
      f2_r <= f1_r;
      c2_r <= z1_r ? '0 : prod[CODE_LSB +: CODE_W];
    end
  end

  assign prod = x1_r * g1_r;

  assign res_push            = v2_r;
  assign res_data.freq_value = f2_r;
  assign res_data.dac_code   = c2_r;

endmodule

`default_nettype wire

// ===== hdl/decimal_frame_to_tuning_code.sv =====
// path: sixth beat, middle queue, back stages v1 and v2, result queue, out_ ports
// throughput: one byte beat per cycle while in_full is low; one result per six beats
// front accumulates digits, a 2-deep queue feeds a 2-stage lookup and 20x24 multiply
// result queue of 4 parts the block from the consumer
// reset: synchronous active-low rst_n clears frame position, accumulator, queues, pipe
`default_nettype none

module decimal_frame_to_tuning_code #(
  parameter int unsigned MID_DEPTH = dftc_pkg::MID_DEPTH_DEF,
  parameter int unsigned OUT_DEPTH = dftc_pkg::OUT_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_push,
  input  wire logic [dftc_pkg::BYTE_W-1:0]  in_rx_byte,
  output logic                              in_full,
  output logic                              out_empty,
  input  wire logic                         out_pop,
  output logic [dftc_pkg::FREQ_W-1:0]       out_freq_value,
  output logic [dftc_pkg::CODE_W-1:0]       out_dac_code
);

  import dftc_pkg::*;

  logic                              mid_full, mid_push, mid_pop, mid_empty;
  logic [FREQ_W-1:0]                 mid_wfreq, mid_rfreq;
  logic [$clog2(MID_DEPTH+1)-1:0]    mid_count;
  logic [$clog2(OUT_DEPTH+1)-1:0]    out_count;
  logic                              res_push;
  logic                              res_full;
  result_t                           res_data, res_head;

  dftc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_rx_byte (in_rx_byte),
    .in_full    (in_full),
    .mid_full   (mid_full),
    .mid_push   (mid_push),
    .mid_freq   (mid_wfreq)
  );

  dftc_queue #(
    .DEPTH (MID_DEPTH),
    .WIDTH (FREQ_W)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wfreq),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rfreq),
    .empty (mid_empty),
    .count (mid_count)
  );

  dftc_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_freq  (mid_rfreq),
    .mid_pop   (mid_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // space is reserved at issue, so res_full is never hit on a push
  dftc_queue #(
    .DEPTH ($bits(result_t) > 0 ? OUT_DEPTH : 1),
    .WIDTH ($bits(result_t))
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_head),
    .empty (out_empty),
    .count (out_count)
  );

  assign out_freq_value = res_head.freq_value;
  assign out_dac_code   = res_head.dac_code;

  // occupancy of the middle queue and full flag of the result queue are not needed here
  logic unused_ok;
  assign unused_ok = ^{mid_count, res_full};

endmodule

`default_nettype wire

// ===== hdl/dftc_chk.sv =====
// port-level checker for decimal_frame_to_tuning_code, attached by bind
// watches the input beat and the result channel; no package dependency
`default_nettype none

module dftc_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic [7:0]  in_rx_byte,
  input wire logic        in_full,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [15:0] out_freq_value,
  input wire logic [11:0] out_dac_code
);

  localparam logic [15:0] F_LO = 16'd1000;
  localparam logic [15:0] F_HI = 16'd2000;

  // nothing is waiting right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // an accepted input beat carries a known byte
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |-> !$isunknown(in_rx_byte))
    else $error("unknown byte accepted on the input");

  // out of band frequency always maps to code zero
  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && (out_freq_value < F_LO || out_freq_value > F_HI)) |-> out_dac_code == 12'd0)
    else $error("nonzero tuning code for out of band frequency");

  // in band frequency gives a nonzero code
  a_inband_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_freq_value >= F_LO && out_freq_value <= F_HI) |-> out_dac_code != 12'd0)
    else $error("zero tuning code for in band frequency");

  // a waiting result holds until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_freq_value)
                                  && $stable(out_dac_code)))
    else $error("waiting result changed before it was taken");

endmodule

bind decimal_frame_to_tuning_code dftc_chk u_dftc_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_push        (in_push),
  .in_rx_byte     (in_rx_byte),
  .in_full        (in_full),
  .out_empty      (out_empty),
  .out_pop        (out_pop),
  .out_freq_value (out_freq_value),
  .out_dac_code   (out_dac_code)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench for decimal_frame_to_tuning_code: six-byte frames in, frequency and tuning code out
// predicts each frame's result on the tb side and checks it field by field; needs dftc_pkg
`timescale 1ns / 100ps

module tb_top;

  import dftc_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned DRAIN_CYCLES  = 12;
  localparam int unsigned FRAMES_PER_MIX = 28;
  localparam int unsigned MAX_SHOWN     = 10;
  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'd48;

  // segment table: inclusive upper bound, offset in q8, gain in q24
  localparam int   SEG_TOP  [5] = '{1200, 1400, 1600, 1800, 2000};
  localparam int   SEG_OFS  [5] = '{37394, -4655, 37076, -14055, 108116};
  localparam longint SEG_GN [5] = '{64'd13677403, 64'd11833318, 64'd13370393,
                                    64'd11756372, 64'd15829029};
  localparam int   EDGE_VALS [6] = '{1000, 1200, 1400, 1600, 1800, 2000};

  logic clk = 1'b0;
  logic rst_n;
  logic in_push;
  logic [BYTE_W-1:0] in_rx_byte;
  logic in_full;
  logic out_empty;
  logic out_pop;
  logic [FREQ_W-1:0] out_freq_value;
  logic [CODE_W-1:0] out_dac_code;

  decimal_frame_to_tuning_code uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_rx_byte     (in_rx_byte),
    .in_full        (in_full),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_freq_value (out_freq_value),
    .out_dac_code   (out_dac_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // tb copy of the frame state
  logic [COUNT_W-1:0] frame_pos;
  logic [FREQ_W-1:0]  digit_sum;
  result_t            pending_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned fail_count;
  int unsigned cycle_count;

  function automatic logic [CODE_W-1:0] tuning_code_of(input logic [FREQ_W-1:0] f);
    longint x;
    longint prod;
    if (f < FREQ_W'(1000) || f > FREQ_W'(2000)) return '0;
    for (int i = 0; i < 5; i++) begin
      if (int'(f) <= SEG_TOP[i]) begin
        x = longint'(f) * 256 - longint'(SEG_OFS[i]);
        if (x < 0) return '0;
        prod = x * SEG_GN[i];
        return CODE_W'(prod >> 32);
      end
    end
    return '0;
  endfunction

  // advance the frame state by one accepted byte, queue a result on the sixth
  function automatic void frame_accept(input logic [BYTE_W-1:0] b);
    logic [FREQ_W-1:0] digit;
    logic [FREQ_W-1:0] weight;
    result_t r;
    if (frame_pos >= POS_THOUSANDS) begin
      case (frame_pos)
        POS_THOUSANDS: weight = 16'd1000;
        POS_HUNDREDS:  weight = 16'd100;
        POS_TENS:      weight = 16'd10;
        default:       weight = 16'd1;
      endcase
      digit = {8'h00, b} - 16'd48;
      digit_sum = digit_sum + FREQ_W'(digit * weight);
    end
    if (frame_pos >= POS_LAST) begin
      r.freq_value = digit_sum;
      r.dac_code   = tuning_code_of(digit_sum);
      pending_results.push_back(r);
      frame_pos = '0;
      digit_sum = '0;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_full) @(posedge clk);
    frame_accept(b);
  endtask

  task automatic send_value(input int v);
    send_byte(BYTE_W'($urandom_range(0, 255)));
    send_byte(BYTE_W'($urandom_range(0, 255)));
    send_byte(ASCII_ZERO + BYTE_W'((v / 1000) % 10));
    send_byte(ASCII_ZERO + BYTE_W'((v / 100) % 10));
    send_byte(ASCII_ZERO + BYTE_W'((v / 10) % 10));
    send_byte(ASCII_ZERO + BYTE_W'(v % 10));
  endtask

  // result side: check the beat taken at this edge, then pick the next pop
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_SHOWN)
            $display("unexpected result: freq %0d code %0d", out_freq_value, out_dac_code);
        end else begin
          want = pending_results.pop_front();
          if (out_freq_value !== want.freq_value || out_dac_code !== want.dac_code) begin
            fail_count++;
            if (fail_count <= MAX_SHOWN)
              $display("mismatch: exp freq %0d code %0d, got freq %0d code %0d",
                       want.freq_value, want.dac_code, out_freq_value, out_dac_code);
          end
        end
      end
      out_pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // lower bound of the first segment, top of the last, just below range
  task automatic test_segment_edges();
    send_value(1000);
    send_value(2000);
    send_value(999);
  endtask

  // bytes outside '0'..'9' still count, with 16-bit wrap
  task automatic test_non_digits();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h3A);
    send_byte(8'h2F);
  endtask

  task automatic test_random_frames(input int unsigned idle_pct, input int unsigned stall_pct);
    int v;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < FRAMES_PER_MIX; n++) begin
      if ($urandom_range(0, 99) < 20) begin
        for (int k = 0; k < 6; k++) send_byte(BYTE_W'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 3))
          0:       v = EDGE_VALS[$urandom_range(0, 5)] + int'($urandom_range(0, 2)) - 1;
          1:       v = $urandom_range(1000, 2000);
          2:       v = $urandom_range(900, 2100);
          default: v = $urandom_range(0, 9999);
        endcase
        send_value(v);
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_push        <= 1'b0;
    in_rx_byte     <= '0;
    frame_pos      = '0;
    digit_sum      = '0;
    fail_count     = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_segment_edges();
    test_non_digits();
    test_random_frames(0, 0);
    test_random_frames(53, 0);
    test_random_frames(0, 53);
    test_random_frames(17, 17);

    in_push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== decimal_frame_to_tuning_code.f =====
hdl/dftc_pkg.sv
hdl/dftc_queue.sv
hdl/dftc_front.sv
hdl/dftc_back.sv
hdl/decimal_frame_to_tuning_code.sv
hdl/dftc_chk.sv
tb/sv/tb_top.sv
